// ===== sv/u8sts_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sts_pkg
// Types, constants and lookup functions for the UTF-8 speech text sanitiser.
// ----------------------------------------------------------------------------
package u8sts_pkg;

  localparam int FifoDepth    = 8;
  localparam int FifoPtrWidth = $clog2(FifoDepth);
  localparam int MaxResults   = 3;
  localparam int PuncEntries  = 21;

  localparam logic [7:0] MaskLead2 = 8'hE0;
  localparam logic [7:0] CodeLead2 = 8'hC0;
  localparam logic [7:0] MaskLead3 = 8'hF0;
  localparam logic [7:0] CodeLead3 = 8'hE0;
  localparam logic [7:0] MaskLead4 = 8'hF8;
  localparam logic [7:0] CodeLead4 = 8'hF0;
  localparam logic [7:0] AsciiTop  = 8'h80;

  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       text_done;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ascii;
  } punc_hit_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] ascii;
  } punc_entry_t;

  localparam punc_entry_t PuncTable [PuncEntries] = '{
    '{8'hEF, 8'hBC, 8'h8C, 8'h2C}, '{8'hE3, 8'h80, 8'h81, 8'h2C},
    '{8'hEF, 8'hBC, 8'h9A, 8'h2C}, '{8'hEF, 8'hBC, 8'h9B, 8'h2C},
    '{8'hE3, 8'h80, 8'h82, 8'h2E}, '{8'hEF, 8'hBC, 8'h81, 8'h21},
    '{8'hEF, 8'hBC, 8'h9F, 8'h3F},
    '{8'hE2, 8'h80, 8'h9C, 8'h27}, '{8'hE2, 8'h80, 8'h9D, 8'h27},
    '{8'hE2, 8'h80, 8'h98, 8'h27}, '{8'hE2, 8'h80, 8'h99, 8'h27},
    '{8'hEF, 8'hBC, 8'h88, 8'h27}, '{8'hEF, 8'hBC, 8'h89, 8'h27},
    '{8'hE3, 8'h80, 8'h8A, 8'h27}, '{8'hE3, 8'h80, 8'h8B, 8'h27},
    '{8'hE3, 8'h80, 8'h90, 8'h27}, '{8'hE3, 8'h80, 8'h91, 8'h27},
    '{8'hE3, 8'h80, 8'h8C, 8'h27}, '{8'hE3, 8'h80, 8'h8D, 8'h27},
    '{8'hE2, 8'h80, 8'h94, 8'h2D}, '{8'hEF, 8'hBD, 8'h9E, 8'h2D}
  };

  function automatic logic ascii_kept(input logic [7:0] c);
    logic keep;
    keep = ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == 8'h20) || (c == 8'h0A) || (c == 8'h2C) || (c == 8'h2E) ||
           (c == 8'h21) || (c == 8'h3F) || (c == 8'h27) || (c == 8'h2D);
    return keep;
  endfunction

  // first match wins, as entries are unique this is also the only match
  function automatic punc_hit_t punc_lookup(input logic [7:0] b0,
                                            input logic [7:0] b1,
                                            input logic [7:0] b2);
    punc_hit_t res;
    res = '0;
    for (int i = PuncEntries - 1; i >= 0; i--) begin
      if (PuncTable[i].b0 == b0 && PuncTable[i].b1 == b1 && PuncTable[i].b2 == b2) begin
        res.hit   = 1'b1;
        res.ascii = PuncTable[i].ascii;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/utf8_speech_text_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_speech_text_sanitizer
// Filters a UTF-8 byte stream for speech: keeps plain ASCII text, passes
// 2/3-byte chars whole, drops 4-byte ones, maps full-width punctuation to ASCII.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_ready  | in_byte, end_of_text
// out     | out_valid/out_ready| out_byte, byte_valid, last_of_run, text_done
//
// An item is registered on accept and decoded the next cycle into 0..3
// results, which enter an 8-entry result FIFO; out is driven from its head.
// One item per cycle is taken while the FIFO holds room for the results of
// the item in the decode stage plus three more; one result leaves per cycle
// while out_ready is high. Synchronous reset empties the FIFO and closes any
// open character.
// ----------------------------------------------------------------------------
module utf8_speech_text_sanitizer
  import u8sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       text_done
);

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eot;

  // character state
  logic [2:0] char_length, char_length_next;
  logic [1:0] bytes_taken, bytes_taken_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;

  // result FIFO
  result_t                 fifo [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_ptr;
  logic [FifoPtrWidth-1:0] rd_ptr;
  logic [FifoPtrWidth:0]   count;

  result_t    ent [MaxResults];
  logic [1:0] n_res;
  logic [1:0] stage_n;
  punc_hit_t  punc;
  logic       in_fire;
  logic       out_fire;

  always_comb begin
    punc             = punc_lookup(held0, held1, stage_byte);
    char_length_next = char_length;
    bytes_taken_next = bytes_taken;
    held0_next       = held0;
    held1_next       = held1;
    n_res            = 2'd0;
    for (int k = 0; k < MaxResults; k++) begin
      ent[k] = '0;
    end

    if (char_length == LenNone) begin
      if (stage_byte < AsciiTop) begin
        if (ascii_kept(stage_byte)) begin
          ent[0] = '{stage_byte, 1'b1, 1'b0, 1'b0};
          n_res  = 2'd1;
        end
      end else if ((stage_byte & MaskLead2) == CodeLead2) begin
        char_length_next = LenTwo;
        bytes_taken_next = 2'd1;
        held0_next       = stage_byte;
      end else if ((stage_byte & MaskLead3) == CodeLead3) begin
        char_length_next = LenThree;
        bytes_taken_next = 2'd1;
        held0_next       = stage_byte;
      end else if ((stage_byte & MaskLead4) == CodeLead4) begin
        char_length_next = LenFour;
        bytes_taken_next = 2'd1;
        held0_next       = stage_byte;
      end
    end else if (({1'b0, bytes_taken} + 3'd1) == char_length) begin
      case (char_length)
        LenTwo: begin
          ent[0] = '{held0, 1'b1, 1'b0, 1'b0};
          ent[1] = '{stage_byte, 1'b1, 1'b0, 1'b0};
          n_res  = 2'd2;
        end
        LenThree: begin
          if (punc.hit) begin
            ent[0] = '{punc.ascii, 1'b1, 1'b0, 1'b0};
            n_res  = 2'd1;
          end else begin
            ent[0] = '{held0, 1'b1, 1'b0, 1'b0};
            ent[1] = '{held1, 1'b1, 1'b0, 1'b0};
            ent[2] = '{stage_byte, 1'b1, 1'b0, 1'b0};
            n_res  = 2'd3;
          end
        end
        default: begin
        end
      endcase
      char_length_next = LenNone;
      bytes_taken_next = 2'd0;
    end else begin
      if (bytes_taken == 2'd1) begin
        held1_next = stage_byte;
      end
      bytes_taken_next = bytes_taken + 2'd1;
    end

    if (stage_eot) begin
      char_length_next = LenNone;
      bytes_taken_next = 2'd0;
      if (n_res == 2'd0) begin
        ent[0] = '{8'h00, 1'b0, 1'b0, 1'b1};
        n_res  = 2'd1;
      end else begin
        ent[n_res - 2'd1].text_done = 1'b1;
      end
    end
    if (n_res != 2'd0) begin
      ent[n_res - 2'd1].last_of_run = 1'b1;
    end
  end

  assign stage_n   = stage_valid ? n_res : 2'd0;
  assign in_ready  = ({1'b0, count} + {3'b000, stage_n})
                     <= (FifoPtrWidth + 2)'(FifoDepth - MaxResults);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;

  assign out_byte    = fifo[rd_ptr].out_byte;
  assign byte_valid  = fifo[rd_ptr].byte_valid;
  assign last_of_run = fifo[rd_ptr].last_of_run;
  assign text_done   = fifo[rd_ptr].text_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      char_length <= LenNone;
      bytes_taken <= 2'd0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      stage_valid <= in_fire;
      if (stage_valid) begin
        char_length <= char_length_next;
        bytes_taken <= bytes_taken_next;
      end
      wr_ptr <= wr_ptr + FifoPtrWidth'(stage_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FifoPtrWidth + 1)'(stage_n) - (FifoPtrWidth + 1)'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_byte <= in_byte;
      stage_eot  <= end_of_text;
    end
    if (stage_valid) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
    for (int k = 0; k < MaxResults; k++) begin
      if (2'(k) < stage_n) begin
        fifo[wr_ptr + FifoPtrWidth'(k)] <= ent[k];
      end
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FifoPtrWidth + 1)'(FifoDepth))
    else $error("result FIFO overfilled");

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (last_of_run && text_done))
    else $error("end marker without last and done flags");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_done) |-> last_of_run)
    else $error("text done on a result that is not last of its run");

  a_eot_closes: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage_eot) |=> (char_length == LenNone && bytes_taken == 2'd0))
    else $error("character left open after end of text");

endmodule
